// File: hw/rtl/turtle_vector_stepper_top_macros.svh
// Assertion macros shared by the turtle vector stepper RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef TURTLE_VECTOR_STEPPER_TOP_MACROS_SVH
`define TURTLE_VECTOR_STEPPER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TVS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tvs_pkg.sv
package tvs_pkg;

    // Field widths
    localparam int OP_W   = 3;
    localparam int AMT_W  = 32;
    localparam int POS_W  = 32;
    localparam int HDG_W  = 25;
    localparam int ST_W   = 2;
    localparam int STEP_W = 5;
    localparam int SAVE_W = 2 * POS_W + HDG_W;

    // Datapath widths
    localparam int TRIG_W     = 34;
    localparam int ANG_W      = 25;
    localparam int ATAN_W     = 22;
    localparam int RED_W      = 34;
    localparam int PROD_W     = AMT_W + TRIG_W;
    localparam int FRAC_SHIFT = 30;
    localparam int SUM_W      = POS_W + 6;

    // Opcodes
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP   = 3'd1;
    localparam logic [OP_W-1:0] OP_TURN  = 3'd2;
    localparam logic [OP_W-1:0] OP_TRACE = 3'd3;
    localparam logic [OP_W-1:0] OP_MOVE  = 3'd4;

    // Result status codes
    localparam logic [ST_W-1:0] ST_DRAWN     = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

    // Angles in Q16 degrees
    localparam logic [HDG_W-1:0] DEG_90  = 25'd5898240;
    localparam logic [HDG_W-1:0] DEG_180 = 25'd11796480;
    localparam logic [HDG_W-1:0] DEG_270 = 25'd17694720;
    localparam logic [HDG_W-1:0] DEG_360 = 25'd23592960;

    // 360 degrees shifted up by the top reduction step; makes any heading sum positive
    localparam logic [RED_W:0]      WRAP_BIAS = 35'd6039797760;
    localparam logic [STEP_W-1:0]   WRAP_TOP  = 5'd8;

    // CORDIC start value, gain 0.6072529350 in Q2.30
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic              load;
        logic              push;
        logic              pop;
        logic              pop_load;
        logic              wrap_step;
        logic              wrap_done;
        logic              rot_step;
        logic              mul_cos;
        logic              upd_x;
        logic              upd_y;
        logic              emit;
        logic [STEP_W-1:0] step;
        logic [ST_W-1:0]   code;
    } tvs_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tvs_sts_t;

    // atan(2^-i) in Q16 degrees, rounded
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/tvs_ram.sv
module tvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/tvs_ctrl.sv
`include "turtle_vector_stepper_top_macros.svh"

module tvs_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [tvs_pkg::OP_W-1:0]  opcode,
    output logic                      out_valid,
    input  logic                      out_stall,
    output tvs_pkg::tvs_cmd_t         cmd,
    input  tvs_pkg::tvs_sts_t         sts
);

    import tvs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WRAP = 3'd1;
    localparam logic [2:0] S_ROT  = 3'd2;
    localparam logic [2:0] S_MULX = 3'd3;
    localparam logic [2:0] S_MULY = 3'd4;
    localparam logic [2:0] S_ADDY = 3'd5;
    localparam logic [2:0] S_POP  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(CORDIC_STEPS - 1);

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              trace_reg, trace_next;
    logic [ST_W-1:0]   code_reg, code_next;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        trace_next = trace_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.code   = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (opcode)
                        OP_PUSH:
                        begin
                            if (sts.full)
                            begin
                                code_next  = ST_OVERFLOW;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (sts.empty)
                            begin
                                code_next  = ST_UNDERFLOW;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                cmd.pop    = 1'b1;
                                state_next = S_POP;
                            end
                        end
                        OP_TURN:
                        begin
                            step_next  = WRAP_TOP;
                            state_next = S_WRAP;
                        end
                        OP_TRACE, OP_MOVE:
                        begin
                            step_next  = '0;
                            trace_next = (opcode == OP_TRACE);
                            code_next  = ST_DRAWN;
                            state_next = S_ROT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WRAP:
            begin
                cmd.wrap_step = 1'b1;
                if (step_reg == '0)
                begin
                    cmd.wrap_done = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            S_ROT:
            begin
                cmd.rot_step = 1'b1;
                if (step_reg == ROT_LAST)
                begin
                    state_next = S_MULX;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_MULX:
            begin
                cmd.mul_cos = 1'b1;
                state_next  = S_MULY;
            end
            S_MULY:
            begin
                cmd.upd_x  = 1'b1;
                state_next = S_ADDY;
            end
            S_ADDY:
            begin
                cmd.upd_y  = 1'b1;
                state_next = trace_reg ? S_EMIT : S_IDLE;
            end
            S_POP:
            begin
                cmd.pop_load = 1'b1;
                state_next   = S_IDLE;
            end
            S_EMIT:
            begin
                // hold until the output register is free or being emptied
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.emit ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            trace_reg     <= 1'b0;
            code_reg      <= ST_DRAWN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            trace_reg     <= trace_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TVS_ASSERT_NOW(a_emit_no_clobber, cmd.emit, !(out_valid_reg && out_stall), "result overwritten")
    `TVS_ASSERT_NEXT(a_wrap_ends, (state_reg == S_WRAP) && (step_reg == '0), state_reg == S_IDLE, "wrap did not end")
    `TVS_ASSERT_NOW(a_rot_bound, state_reg == S_ROT, step_reg <= ROT_LAST, "rotation step out of range")

endmodule

// File: hw/rtl/tvs_dp.sv
`include "turtle_vector_stepper_top_macros.svh"

module tvs_dp #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tvs_pkg::tvs_cmd_t                 cmd,
    output tvs_pkg::tvs_sts_t                 sts,
    input  logic signed [tvs_pkg::AMT_W-1:0]  amount,
    output logic [tvs_pkg::ST_W-1:0]          status,
    output logic signed [tvs_pkg::POS_W-1:0]  start_x,
    output logic signed [tvs_pkg::POS_W-1:0]  start_y,
    output logic signed [tvs_pkg::POS_W-1:0]  end_x,
    output logic signed [tvs_pkg::POS_W-1:0]  end_y
);

    import tvs_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Architectural state
    logic signed [POS_W-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0] pos_y_reg, pos_y_next;
    logic [HDG_W-1:0]        heading_reg, heading_next;
    logic [CNT_W-1:0]        count_reg, count_next;

    // Working registers
    logic signed [AMT_W-1:0]  amt_reg;
    logic signed [POS_W-1:0]  sx_reg, sy_reg;
    logic [RED_W-1:0]         red_reg;
    logic signed [TRIG_W-1:0] cx_reg, cy_reg;
    logic signed [ANG_W-1:0]  cz_reg;
    logic [1:0]               quad_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // Result payload
    logic [ST_W-1:0]         status_reg;
    logic signed [POS_W-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;

    // Combinational
    logic [1:0]               quad;
    logic [HDG_W-1:0]         quad_base, resid;
    logic signed [RED_W:0]    turn_sum, turn_adj;
    logic [RED_W-1:0]         wrap_cand, red_stepped;
    logic signed [TRIG_W-1:0] dx, dy;
    logic signed [ANG_W-1:0]  at;
    logic signed [TRIG_W-1:0] cos_v, sin_v, trig_op;
    logic signed [POS_W-1:0]  upd_base, upd_sat;
    logic signed [SUM_W-1:0]  upd_sum;
    logic [CNT_W-1:0]         rd_cnt;
    logic [SAVE_W-1:0]        ram_wdata, ram_rdata;

    // Quadrant reduction of the heading
    always_comb
    begin
        if (heading_reg >= DEG_270)
        begin
            quad      = 2'd3;
            quad_base = DEG_270;
        end
        else if (heading_reg >= DEG_180)
        begin
            quad      = 2'd2;
            quad_base = DEG_180;
        end
        else if (heading_reg >= DEG_90)
        begin
            quad      = 2'd1;
            quad_base = DEG_90;
        end
        else
        begin
            quad      = 2'd0;
            quad_base = '0;
        end
        resid = heading_reg - quad_base;
    end

    // Heading wrap: bias negative sums up, then subtract 360 << k for k down to 0
    always_comb
    begin
        turn_sum = $signed({{(RED_W + 1 - HDG_W){1'b0}}, heading_reg})
                 + $signed({{(RED_W + 1 - AMT_W){amount[AMT_W-1]}}, amount});
        turn_adj = turn_sum[RED_W] ? (turn_sum + $signed(WRAP_BIAS)) : turn_sum;
        wrap_cand   = {{(RED_W - HDG_W){1'b0}}, DEG_360} << cmd.step;
        red_stepped = (red_reg >= wrap_cand) ? (red_reg - wrap_cand) : red_reg;
    end

    // CORDIC rotation step
    assign dx = cy_reg >>> cmd.step;
    assign dy = cx_reg >>> cmd.step;
    assign at = $signed({{(ANG_W - ATAN_W){1'b0}}, atan_q16(cmd.step)});

    // Rotate the first-quadrant result into place
    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_v = cx_reg;
                sin_v = cy_reg;
            end
            2'd1:
            begin
                cos_v = -cy_reg;
                sin_v = cx_reg;
            end
            2'd2:
            begin
                cos_v = -cx_reg;
                sin_v = -cy_reg;
            end
            default:
            begin
                cos_v = cy_reg;
                sin_v = -cx_reg;
            end
        endcase
    end

    assign trig_op = cmd.mul_cos ? cos_v : sin_v;

    // Position update: round half up, then saturate to 32 bits
    always_comb
    begin
        upd_base = cmd.upd_y ? pos_y_reg : pos_x_reg;
        upd_sum  = SUM_W'(upd_base)
                 + SUM_W'($signed(prod_reg[PROD_W-1:FRAC_SHIFT]))
                 + SUM_W'(prod_reg[FRAC_SHIFT-1]);
        if ((&upd_sum[SUM_W-1:POS_W-1]) || !(|upd_sum[SUM_W-1:POS_W-1]))
        begin
            upd_sat = upd_sum[POS_W-1:0];
        end
        else if (upd_sum[SUM_W-1])
        begin
            upd_sat = {1'b1, {(POS_W - 1){1'b0}}};
        end
        else
        begin
            upd_sat = {1'b0, {(POS_W - 1){1'b1}}};
        end
    end

    // Save stack
    assign rd_cnt    = count_reg - CNT_W'(1);
    assign ram_wdata = {pos_x_reg, pos_y_reg, heading_reg};

    tvs_ram #(
        .WIDTH (SAVE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (cmd.pop),
        .raddr (rd_cnt[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign sts.full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign sts.empty = (count_reg == '0);

    always_comb
    begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        heading_next = heading_reg;
        count_next   = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.pop)
        begin
            count_next = rd_cnt;
        end
        if (cmd.pop_load)
        begin
            pos_x_next   = ram_rdata[SAVE_W-1 -: POS_W];
            pos_y_next   = ram_rdata[HDG_W +: POS_W];
            heading_next = ram_rdata[HDG_W-1:0];
        end
        if (cmd.wrap_done)
        begin
            heading_next = red_stepped[HDG_W-1:0];
        end
        if (cmd.upd_x)
        begin
            pos_x_next = upd_sat;
        end
        if (cmd.upd_y)
        begin
            pos_y_next = upd_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            heading_reg <= heading_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            amt_reg  <= amount;
            sx_reg   <= pos_x_reg;
            sy_reg   <= pos_y_reg;
            red_reg  <= turn_adj[RED_W-1:0];
            cx_reg   <= CORDIC_GAIN;
            cy_reg   <= '0;
            cz_reg   <= $signed(resid);
            quad_reg <= quad;
        end
        if (cmd.wrap_step)
        begin
            red_reg <= red_stepped;
        end
        if (cmd.rot_step)
        begin
            if (!cz_reg[ANG_W-1])
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + at;
            end
        end
        if (cmd.mul_cos || cmd.upd_x)
        begin
            prod_reg <= amt_reg * trig_op;
        end
        if (cmd.emit)
        begin
            status_reg <= cmd.code;
            if (cmd.code == ST_DRAWN)
            begin
                start_x_reg <= sx_reg;
                start_y_reg <= sy_reg;
                end_x_reg   <= pos_x_reg;
                end_y_reg   <= pos_y_reg;
            end
            else
            begin
                start_x_reg <= '0;
                start_y_reg <= '0;
                end_x_reg   <= '0;
                end_y_reg   <= '0;
            end
        end
    end

    assign status  = status_reg;
    assign start_x = start_x_reg;
    assign start_y = start_y_reg;
    assign end_x   = end_x_reg;
    assign end_y   = end_y_reg;

    `TVS_ASSERT_NOW(a_heading_range, 1'b1, heading_reg < DEG_360, "heading out of range")
    `TVS_ASSERT_NOW(a_push_room, cmd.push, count_reg != CNT_W'(STACK_DEPTH), "push on full stack")
    `TVS_ASSERT_NOW(a_pop_data, cmd.pop, count_reg != '0, "pop on empty stack")

endmodule

// File: hw/rtl/turtle_vector_stepper_top.sv
// Push is done on accept; pop reads the stack, then loads the saved pose; turn runs
// nine restoring reduction steps on the heading. Move runs one rotation per cycle, then
// two multiplies through one shared multiplier and the position updates. Trace then
// loads the result register in its emit state, which waits while a held result is stalled.
// Reset (rst_n, async low) clears position, heading, stack count and the handshake;
// stack memory is not cleared.
module turtle_vector_stepper_top #(
    parameter int STACK_DEPTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tvs_pkg::OP_W-1:0]          opcode,
    input  logic signed [tvs_pkg::AMT_W-1:0]  amount,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tvs_pkg::ST_W-1:0]          status,
    output logic signed [tvs_pkg::POS_W-1:0]  start_x,
    output logic signed [tvs_pkg::POS_W-1:0]  start_y,
    output logic signed [tvs_pkg::POS_W-1:0]  end_x,
    output logic signed [tvs_pkg::POS_W-1:0]  end_y
);

    import tvs_pkg::*;

    // Controller <-> datapath command and status
    tvs_cmd_t cmd;
    tvs_sts_t sts;

    // Controller: one item at a time. An item is taken only in idle; the result
    // register sits in the datapath, so a finished trace or stack error waits there
    // while the next item is already taken. A second result holds the controller
    // in its emit state until the downstream side drains the register.
    tvs_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Datapath: position, heading, save stack (simple dual-port RAM with a
    // registered read), heading wrap reducer, CORDIC rotator, one 32x34 multiplier
    // with rounding and saturation, and the result register.
    tvs_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .amount  (amount),
        .status  (status),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y)
    );

endmodule

// File: tb/sv/tb_turtle_vector_stepper_top.sv
module tb_turtle_vector_stepper_top;
    import tvs_pkg::*;

    // Sizes of the block as built here; the predictor keeps the same ones.
    localparam int N_SAVE = 16;
    localparam int N_ROT  = 16;

    // Reserved opcodes: the block must swallow them without a trace.
    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    localparam longint GAIN_Q30  = 64'sd652032874;
    localparam longint HALF_Q30  = 64'sd536870912;
    localparam longint INT32_HI  = 64'sd2147483647;
    localparam longint INT32_LO  = -64'sd2147483648;

    // atan(2^-i) in Q16 degrees, rounded
    localparam longint ATAN_Q16 [32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    localparam int N_DIR        = 13;
    localparam int HOLD_CYCLES  = 600;
    localparam int BURST_TRACES = 40;
    localparam int PHASE_ITEMS  = 310;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_SHOWN    = 40;

    // One drawn segment or one stack error, as it leaves the block.
    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic signed [POS_W-1:0] ex;
        logic signed [POS_W-1:0] ey;
    } segment_t;

    typedef struct {
        int               x;
        int               y;
        logic [HDG_W-1:0] hdg;
    } saved_pose_t;

    // One row of the directed table. Rows marked typed carry a result whose
    // coordinates are all zero, so only the status needs spelling out.
    typedef struct {
        logic [OP_W-1:0] op;
        int              amt;
        int              reps;
        bit              typed;
        logic [ST_W-1:0] st;
    } stim_row_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          opcode    = OP_PUSH;
    logic signed [AMT_W-1:0]  amount    = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [ST_W-1:0]          status;
    logic signed [POS_W-1:0]  start_x;
    logic signed [POS_W-1:0]  start_y;
    logic signed [POS_W-1:0]  end_x;
    logic signed [POS_W-1:0]  end_y;

    // Typed expectation riding along with the item on the input side.
    bit                       row_typed  = 1'b0;
    logic [ST_W-1:0]          row_status = ST_DRAWN;

    // Turtle state as the predictor sees it.
    int                       pose_x     = 0;
    int                       pose_y     = 0;
    logic [HDG_W-1:0]         pose_hdg   = '0;
    saved_pose_t              save_stack [N_SAVE];
    int                       save_depth = 0;

    segment_t                 pending_segs [$];
    int                       mismatch_count = 0;

    // Idle knobs: the driver owns send_idle_pct, the receiver reads stall_pct.
    int                       send_idle_pct = 0;
    int                       stall_pct     = 0;
    int                       hold_request  = 0;
    bit                       hold_taken    = 1'b0;
    int                       hold_left     = 0;

    stim_row_t                dir_rows [N_DIR];

    always #5 clk = ~clk;

    turtle_vector_stepper_top #(
        .STACK_DEPTH  (N_SAVE),
        .CORDIC_STEPS (N_ROT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .amount    (amount),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Rotate a unit vector to the heading: reduce to a quadrant, run the
    // fixed number of CORDIC micro-rotations, then fold the quadrant back.
    function automatic void heading_sin_cos(input logic [HDG_W-1:0] hdg,
                                            output longint cosv, output longint sinv);
        longint x, y, z, t, dx, dy, quad;
        int     i;
        x    = GAIN_Q30;
        y    = 0;
        quad = (longint'(hdg) / longint'(DEG_90)) & 3;
        z    = longint'(hdg) - quad * longint'(DEG_90);
        for (i = 0; i < N_ROT; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_Q16[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_Q16[i];
            end
        end
        case (quad)
            1:
            begin
                t = x;
                x = -y;
                y = t;
            end
            2:
            begin
                x = -x;
                y = -y;
            end
            3:
            begin
                t = x;
                x = y;
                y = -t;
            end
            default:
            begin
            end
        endcase
        cosv = x;
        sinv = y;
    endfunction

    // Distance times a Q2.30 trig value, back to Q16.16, rounding half up.
    function automatic longint scale_by_trig(input int amt, input longint trig);
        return (longint'(amt) * trig + HALF_Q30) >>> 30;
    endfunction

    function automatic int clamp_q16(input longint v);
        if (v > INT32_HI)
            return int'(INT32_HI);
        if (v < INT32_LO)
            return int'(INT32_LO);
        return int'(v);
    endfunction

    // Apply one command to the turtle; return 1 when it produces a result.
    function automatic bit turtle_step(input logic [OP_W-1:0] op, input int amt,
                                       output segment_t seg);
        longint cosv, sinv, r;
        int     x0, y0;
        seg = '0;
        x0  = pose_x;
        y0  = pose_y;
        case (op)
            OP_PUSH:
            begin
                if (save_depth >= N_SAVE)
                begin
                    seg.status = ST_OVERFLOW;
                    return 1'b1;
                end
                save_stack[save_depth].x   = pose_x;
                save_stack[save_depth].y   = pose_y;
                save_stack[save_depth].hdg = pose_hdg;
                save_depth++;
            end
            OP_POP:
            begin
                if (save_depth == 0)
                begin
                    seg.status = ST_UNDERFLOW;
                    return 1'b1;
                end
                save_depth--;
                pose_x   = save_stack[save_depth].x;
                pose_y   = save_stack[save_depth].y;
                pose_hdg = save_stack[save_depth].hdg;
            end
            OP_TURN:
            begin
                r = (longint'(pose_hdg) + longint'(amt)) % longint'(DEG_360);
                if (r < 0)
                    r = r + longint'(DEG_360);
                pose_hdg = r[HDG_W-1:0];
            end
            OP_TRACE, OP_MOVE:
            begin
                heading_sin_cos(pose_hdg, cosv, sinv);
                pose_x = clamp_q16(longint'(pose_x) + scale_by_trig(amt, cosv));
                pose_y = clamp_q16(longint'(pose_y) + scale_by_trig(amt, sinv));
                if (op == OP_TRACE)
                begin
                    seg.status = ST_DRAWN;
                    seg.sx     = x0;
                    seg.sy     = y0;
                    seg.ex     = pose_x;
                    seg.ey     = pose_y;
                    return 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_SHOWN)
            $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // Check results before taking in new items, all in one process, so an
    // item accepted on the same edge can never be mistaken for the one due.
    always @(posedge clk)
    begin : scoreboard
        segment_t want;
        segment_t seg;
        bit       made;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_segs.size() == 0)
            begin
                report_mismatch("result with nothing pending");
            end
            else
            begin
                want = pending_segs.pop_front();
                check_field("status",  32'(status), 32'(want.status));
                check_field("start_x", start_x, want.sx);
                check_field("start_y", start_y, want.sy);
                check_field("end_x",   end_x,   want.ex);
                check_field("end_y",   end_y,   want.ey);
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            made = turtle_step(opcode, amount, seg);
            // A typed row overrides the predictor: its result is known outright.
            if (row_typed)
            begin
                seg        = '0;
                seg.status = row_status;
                made       = 1'b1;
            end
            if (made)
                pending_segs = {pending_segs, seg};
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off when the driver asks
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (hold_request != 0 && !hold_taken)
        begin
            hold_left  <= hold_request;
            hold_taken <= 1'b1;
            out_stall  <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Distances: mostly short hops so the turtle stays on the plane, with
    // enough huge and extreme ones to drive the position into saturation.
    function automatic int rand_distance();
        int mag;
        case ($urandom_range(9))
            7:
                return int'($urandom);
            8:
            begin
                case ($urandom_range(3))
                    0:       return int'(32'h7fff_ffff);
                    1:       return int'(32'h8000_0000);
                    2:       return 1;
                    default: return -1;
                endcase
            end
            9:
                mag = int'($urandom_range(0, 1 << 24));
            default:
                mag = int'($urandom_range(0, 64 << 16));
        endcase
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // Angles: whole quadrants hit the reduction edges exactly; the rest covers turns
    // of up to two circles, near-full turns, hairline turns and the full 32-bit range.
    function automatic int rand_degrees();
        int mag;
        case ($urandom_range(9))
            0, 1, 2, 3:
                return (int'($urandom_range(16)) - 8) * int'(DEG_90);
            7:
                return int'(DEG_360) - int'($urandom_range(1, 255));
            8:
                return int'($urandom);
            9:
                return int'($urandom_range(2)) - 1;
            default:
                mag = int'($urandom_range(0, 720 << 16));
        endcase
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // Offer one item and hold it until the block takes it. Valid only drops
    // while idling, so back-to-back items keep it high across the edge.
    task automatic send_item(input logic [OP_W-1:0] op, input int amt,
                             input bit typed, input logic [ST_W-1:0] st);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        amount     <= amt;
        row_typed  <= typed;
        row_status <= st;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Random traffic. Branches (save, turn, draw, restore) are how turtle
    // programs really look and keep the stack busy; bursts of pushes and
    // pops drive it to full and empty; the rest is loose single commands.
    task automatic run_random(input int n_items);
        int              sent, k, n;
        logic [OP_W-1:0] op;
        int              amt;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    n = $urandom_range(1, 4);
                    send_item(OP_PUSH, $urandom, 1'b0, ST_DRAWN);
                    send_item(OP_TURN, rand_degrees(), 1'b0, ST_DRAWN);
                    for (k = 0; k < n; k++)
                        send_item($urandom_range(2) != 0 ? OP_TRACE : OP_MOVE,
                                  rand_distance(), 1'b0, ST_DRAWN);
                    send_item(OP_POP, $urandom, 1'b0, ST_DRAWN);
                    sent += n + 3;
                end
                2:
                begin
                    n = $urandom_range(3, N_SAVE + 2);
                    for (k = 0; k < n; k++)
                        send_item(OP_PUSH, $urandom, 1'b0, ST_DRAWN);
                    sent += n;
                end
                3:
                begin
                    n = $urandom_range(2, 10);
                    for (k = 0; k < n; k++)
                        send_item(OP_POP, $urandom, 1'b0, ST_DRAWN);
                    sent += n;
                end
                default:
                begin
                    case ($urandom_range(19))
                        0, 1, 2:            op = OP_PUSH;
                        3, 4, 5:            op = OP_POP;
                        6, 7, 8, 9, 10:     op = OP_TURN;
                        11, 12, 13, 14, 15: op = OP_TRACE;
                        16, 17, 18:         op = OP_MOVE;
                        default:            op = OP_RSVD_FIRST + 3'($urandom_range(2));
                    endcase
                    if (op == OP_TURN)
                        amt = rand_degrees();
                    else if (op == OP_TRACE || op == OP_MOVE)
                        amt = rand_distance();
                    else
                        amt = int'($urandom);
                    send_item(op, amt, 1'b0, ST_DRAWN);
                    // Reserved opcodes do nothing, so they do not count.
                    if (op <= OP_MOVE)
                        sent++;
                end
            endcase
        end
    endtask

    initial
    begin
        int r, k, ph;

        // Directed part: stack errors, field extremes, every command and a
        // reserved opcode. Only the rows with all-zero coordinates are typed.
        dir_rows = '{
            '{OP_POP,       0,                      1,      1'b1, ST_UNDERFLOW},
            '{OP_TRACE,     0,                      1,      1'b1, ST_DRAWN},
            '{OP_TRACE,     int'(32'h7fff_ffff),    1,      1'b0, ST_DRAWN},
            '{OP_TRACE,     int'(32'h8000_0000),    1,      1'b0, ST_DRAWN},
            '{OP_TURN,      int'(DEG_90),           1,      1'b0, ST_DRAWN},
            '{OP_TRACE,     65536,                  1,      1'b0, ST_DRAWN},
            '{OP_TURN,      int'(32'h8000_0000),    1,      1'b0, ST_DRAWN},
            '{OP_MOVE,      491520,                 1,      1'b0, ST_DRAWN},
            '{OP_TURN,      int'(32'h7fff_ffff),    1,      1'b0, ST_DRAWN},
            '{OP_RSVD_LAST, int'(32'h7fff_ffff),    1,      1'b0, ST_DRAWN},
            '{OP_PUSH,      0,                      N_SAVE, 1'b0, ST_DRAWN},
            '{OP_PUSH,      -1,                     1,      1'b1, ST_OVERFLOW},
            '{OP_POP,       0,                      1,      1'b0, ST_DRAWN}
        };

        // Hold reset low from time zero, then release it at an edge.
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < N_DIR; r++)
            for (k = 0; k < dir_rows[r].reps; k++)
                send_item(dir_rows[r].op, dir_rows[r].amt, dir_rows[r].typed,
                          dir_rows[r].st);

        // Random part in four idle mixes: none, sender idle, receiver stall,
        // and both a little.
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1:
                begin
                    send_idle_pct = 72;
                    stall_pct    <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 72;
                end
                default:
                begin
                    send_idle_pct = 23;
                    stall_pct    <= 23;
                end
            endcase
            // Starve the output for a long stretch and keep pushing traces
            // in, so the block fills and has to stall its input.
            if (ph == 0)
            begin
                hold_request <= HOLD_CYCLES;
                for (k = 0; k < BURST_TRACES; k++)
                    send_item(OP_TRACE, rand_distance(), 1'b0, ST_DRAWN);
            end
            run_random(PHASE_ITEMS);
        end

        // Drop valid, let every expected result arrive, then give the block
        // time to show anything stray.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_segs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
